[hw/rtl/uecpmu_pkg.sv]
`default_nettype none
package uecpmu_pkg;

    localparam int DATA_W    = 32;
    localparam int OFF_W     = 8;
    localparam int PULSE_W   = 8;
    localparam int MASK_W    = 4;
    localparam int IDX_W     = 2;
    localparam int CODE_W    = 8;

    localparam logic [1:0] MODE_RD    = 2'd0;
    localparam logic [1:0] MODE_WR    = 2'd1;
    localparam logic [1:0] MODE_EVENT = 2'd2;

    localparam logic [OFF_W-1:0] OFF_CNT0   = 8'h30;
    localparam logic [OFF_W-1:0] OFF_CTRL   = 8'h40;
    localparam logic [OFF_W-1:0] OFF_EVTYPE = 8'h48;
    localparam logic [OFF_W-1:0] OFF_INTM   = 8'h60;
    localparam logic [OFF_W-1:0] OFF_INTS   = 8'h68;
    localparam logic [OFF_W-1:0] OFF_INTC   = 8'h6C;

    localparam logic [CODE_W-1:0] EVT_NONE = 8'hFF;
    localparam int                CTRL_EN  = 0;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_EVENT,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_CTRL_RD,
        OP_CTRL_WR,
        OP_EVT_RD,
        OP_EVT_WR,
        OP_MASK_RD,
        OP_MASK_WR,
        OP_STAT_RD,
        OP_CLR_WR,
        OP_NOP,
        OP_ERR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  data;
        logic [PULSE_W-1:0] pulses;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              access_error;
        logic              irq;
    } t_res;

endpackage
`default_nettype wire

[hw/rtl/uncore_event_counter_pmu.sv]
`default_nettype none
// Performance monitor with up to four 32-bit event counters behind a simple
// register bus. Each item is a register read or write, one cycle of event
// pulses or an idle item, and every item yields exactly one result in order.
// Items are taken at one per clock while full is low; with pop held high, a
// result on the outputs leaves at the next edge. A two-entry command queue
// after the decoder and a two-entry result queue after the register file let
// each side stall alone, so four items can wait before full is raised.
// The irq field reflects status and mask after the item has taken effect.
module uncore_event_counter_pmu
    import uecpmu_pkg::*;
#(
    parameter int NUM_CTRS        = 4,
    parameter int NUM_EVENT_CODES = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [1:0]         i_mode,
    input  wire logic [OFF_W-1:0]   i_reg_offset,
    input  wire logic [DATA_W-1:0]  i_write_data,
    input  wire logic [PULSE_W-1:0] i_event_pulses,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output logic [DATA_W-1:0]       o_read_data,
    output logic                    o_access_error,
    output logic                    o_irq
);

    logic w_valid;
    logic w_take;
    t_cmd w_cmd;
    t_res w_res;

    uecpmu_front #(
        .NUM_CTRS(NUM_CTRS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_mode        (i_mode),
        .i_reg_offset  (i_reg_offset),
        .i_write_data  (i_write_data),
        .i_event_pulses(i_event_pulses),
        .o_full        (o_full),
        .o_valid       (w_valid),
        .o_cmd         (w_cmd),
        .i_take        (w_take)
    );

    uecpmu_back #(
        .NUM_CTRS       (NUM_CTRS),
        .NUM_EVENT_CODES(NUM_EVENT_CODES)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_valid),
        .i_cmd  (w_cmd),
        .o_take (w_take),
        .o_empty(o_empty),
        .o_res  (w_res),
        .i_pop  (i_pop)
    );

    assign o_read_data    = w_res.read_data;
    assign o_access_error = w_res.access_error;
    assign o_irq          = w_res.irq;

endmodule
`default_nettype wire

[hw/rtl/uecpmu_front.sv]
`default_nettype none
module uecpmu_front
    import uecpmu_pkg::*;
#(
    parameter int NUM_CTRS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [1:0]         i_mode,
    input  wire logic [OFF_W-1:0]   i_reg_offset,
    input  wire logic [DATA_W-1:0]  i_write_data,
    input  wire logic [PULSE_W-1:0] i_event_pulses,
    output logic                    o_full,
    output logic                    o_valid,
    output t_cmd                    o_cmd,
    input  wire logic               i_take
);

    localparam int QD = 2;

    t_cmd             w_cmd;
    logic [OFF_W-1:0] w_rel;
    logic             w_is_cnt;
    logic             w_wr;
    logic             w_push;
    logic             w_pop;

    t_cmd             r_mem [QD];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;

    // classify the access by offset
    always_comb begin
        w_rel    = i_reg_offset - OFF_CNT0;
        w_is_cnt = (i_reg_offset >= OFF_CNT0) && (w_rel[1:0] == 2'b00) &&
                   ({2'b00, w_rel[7:2]} < OFF_W'(NUM_CTRS));
        w_wr     = (i_mode == MODE_WR);
        w_cmd.idx    = w_rel[3:2];
        w_cmd.data   = i_write_data;
        w_cmd.pulses = i_event_pulses;
        if (i_mode == MODE_EVENT) begin
            w_cmd.op = OP_EVENT;
        end else if (i_mode != MODE_RD && i_mode != MODE_WR) begin
            w_cmd.op = OP_IDLE;
        end else if (w_is_cnt) begin
            w_cmd.op = w_wr ? OP_CNT_WR : OP_CNT_RD;
        end else begin
            case (i_reg_offset)
                OFF_CTRL:   w_cmd.op = w_wr ? OP_CTRL_WR : OP_CTRL_RD;
                OFF_EVTYPE: w_cmd.op = w_wr ? OP_EVT_WR : OP_EVT_RD;
                OFF_INTM:   w_cmd.op = w_wr ? OP_MASK_WR : OP_MASK_RD;
                OFF_INTS:   w_cmd.op = w_wr ? OP_NOP : OP_STAT_RD;
                OFF_INTC:   w_cmd.op = w_wr ? OP_CLR_WR : OP_NOP;
                default:    w_cmd.op = OP_ERR;
            endcase
        end
    end

    assign o_full  = (r_cnt == 2'(QD));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/uecpmu_back.sv]
`default_nettype none
module uecpmu_back
    import uecpmu_pkg::*;
#(
    parameter int NUM_CTRS        = 4,
    parameter int NUM_EVENT_CODES = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_cmd i_cmd,
    output logic      o_take,
    output logic      o_empty,
    output t_res      o_res,
    input  wire logic i_pop
);

    localparam int QD = 2;

    logic [DATA_W-1:0] r_ctr [NUM_CTRS];
    logic [DATA_W-1:0] n_ctr [NUM_CTRS];
    logic [DATA_W-1:0] r_evsel, n_evsel;
    logic              r_en, n_en;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [MASK_W-1:0] r_stat, n_stat;

    t_res              w_res;
    logic [CODE_W-1:0] w_code;
    logic              w_pop;

    t_res              r_q [QD];
    logic              r_wp, r_rp;
    logic [1:0]        r_qcnt;

    assign w_pop   = i_pop && !o_empty;
    assign o_empty = (r_qcnt == 2'd0);
    assign o_res   = r_q[r_rp];
    // a slot is free, or one leaves this cycle
    assign o_take  = i_valid && ((r_qcnt != 2'(QD)) || w_pop);

    always_comb begin
        n_ctr   = r_ctr;
        n_evsel = r_evsel;
        n_en    = r_en;
        n_mask  = r_mask;
        n_stat  = r_stat;
        w_code  = '0;
        w_res.read_data    = '0;
        w_res.access_error = 1'b0;
        case (i_cmd.op)
            OP_CNT_RD: begin
                for (int i = 0; i < NUM_CTRS; i++) begin
                    if (i_cmd.idx == IDX_W'(i)) begin
                        w_res.read_data = r_ctr[i];
                    end
                end
            end
            OP_CNT_WR: begin
                for (int i = 0; i < NUM_CTRS; i++) begin
                    if (i_cmd.idx == IDX_W'(i)) begin
                        n_ctr[i] = i_cmd.data;
                    end
                end
            end
            OP_CTRL_RD: w_res.read_data = DATA_W'(r_en);
            OP_CTRL_WR: n_en = i_cmd.data[CTRL_EN];
            OP_EVT_RD:  w_res.read_data = r_evsel;
            OP_EVT_WR:  n_evsel = i_cmd.data;
            OP_MASK_RD: w_res.read_data = DATA_W'(r_mask);
            OP_MASK_WR: n_mask = i_cmd.data[MASK_W-1:0];
            OP_STAT_RD: w_res.read_data = DATA_W'(r_stat);
            OP_CLR_WR:  n_stat = r_stat & ~i_cmd.data[MASK_W-1:0];
            OP_ERR:     w_res.access_error = 1'b1;
            OP_EVENT: begin
                if (r_en) begin
                    for (int i = 0; i < NUM_CTRS; i++) begin
                        w_code = r_evsel[8*i +: CODE_W];
                        if (w_code != EVT_NONE &&
                            w_code < CODE_W'(NUM_EVENT_CODES) &&
                            i_cmd.pulses[w_code[2:0]]) begin
                            n_ctr[i] = r_ctr[i] + DATA_W'(1);
                            // wrap past all ones flags overflow
                            if (&r_ctr[i]) begin
                                n_stat[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        w_res.irq = |(n_stat & ~n_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CTRS; i++) begin
                r_ctr[i] <= '0;
            end
            r_evsel <= '1;
            r_en    <= 1'b0;
            r_mask  <= '1;
            r_stat  <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_qcnt  <= 2'd0;
        end else begin
            if (o_take) begin
                r_ctr   <= n_ctr;
                r_evsel <= n_evsel;
                r_en    <= n_en;
                r_mask  <= n_mask;
                r_stat  <= n_stat;
                r_wp    <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_qcnt <= r_qcnt + 2'(o_take) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_q[r_wp] <= w_res;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/uecpmu_checker.sv]
`default_nettype none
module uecpmu_checker
    import uecpmu_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_push,
    input wire logic              o_full,
    input wire logic              o_empty,
    input wire logic              i_pop,
    input wire logic [DATA_W-1:0] o_read_data,
    input wire logic              o_access_error,
    input wire logic              o_irq
);

    // both queues drain on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    // an unknown offset never returns data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_access_error) |-> (o_read_data == '0))
        else $error("error result carries read data");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
            (!o_empty && $stable(o_read_data) && $stable(o_access_error) &&
             $stable(o_irq)))
        else $error("stalled result changed");

    // nothing pushed and nothing queued yields no result
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !o_full && !i_push) ##1 (o_empty && !i_push) |=> o_empty)
        else $error("result appeared without an item");

endmodule

bind uncore_event_counter_pmu uecpmu_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_push        (i_push),
    .o_full        (o_full),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_read_data   (o_read_data),
    .o_access_error(o_access_error),
    .o_irq         (o_irq)
);
`default_nettype wire

[sim/tb_uncore_event_counter_pmu.sv]
`default_nettype none
module tb_uncore_event_counter_pmu;
    timeunit 1ns;
    timeprecision 1ps;

    import uecpmu_pkg::*;

    localparam logic [1:0] MODE_IDLE   = 2'd3;
    localparam int         NUM_CNT     = 4;
    localparam int         NUM_CODES   = 8;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_WAIT  = 20;
    localparam int         LONG_HOLD   = 150;

    localparam logic [OFF_W-1:0] OFF_CNT1      = OFF_CNT0 + 8'd4;
    localparam logic [OFF_W-1:0] OFF_CNT3      = OFF_CNT0 + 8'(4 * (NUM_CNT - 1));
    localparam logic [OFF_W-1:0] OFF_BAD_ZERO  = 8'h00;
    localparam logic [OFF_W-1:0] OFF_BAD_ALIGN = 8'h31;
    localparam logic [OFF_W-1:0] OFF_BAD_TOP   = 8'hFF;

    localparam logic [DATA_W-1:0]  ALL_ONES    = '1;
    localparam logic [PULSE_W-1:0] ALL_PULSES  = '1;
    // counter 0 on code 0, counter 1 off, counter 2 out of range, counter 3 on top code
    localparam logic [DATA_W-1:0]  EVSEL_MIXED =
        {8'(NUM_CODES - 1), 8'(NUM_CODES), EVT_NONE, 8'd0};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    logic               o_full;
    logic [1:0]         i_mode;
    logic [OFF_W-1:0]   i_reg_offset;
    logic [DATA_W-1:0]  i_write_data;
    logic [PULSE_W-1:0] i_event_pulses;
    logic               o_empty;
    logic               i_pop;
    logic [DATA_W-1:0]  o_read_data;
    logic               o_access_error;
    logic               o_irq;

    // predicted register state
    logic [DATA_W-1:0] cnt_q [NUM_CNT];
    logic [DATA_W-1:0] evsel_q;
    logic              en_q;
    logic [MASK_W-1:0] mask_q;
    logic [MASK_W-1:0] status_q;

    t_res pending_results [$];
    int   err_count         = 0;
    int   cycle_count       = 0;
    int   long_hold_cycles  = 0;
    bit   push_idle_en      = 1'b0;
    bit   pop_idle_en       = 1'b0;

    uncore_event_counter_pmu i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_mode         (i_mode),
        .i_reg_offset   (i_reg_offset),
        .i_write_data   (i_write_data),
        .i_event_pulses (i_event_pulses),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_read_data    (o_read_data),
        .o_access_error (o_access_error),
        .o_irq          (o_irq)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // Apply one item to the predicted registers and return the result it yields.
    function automatic t_res apply_bus_item(input logic [1:0]         mode,
                                            input logic [OFF_W-1:0]   off,
                                            input logic [DATA_W-1:0]  data,
                                            input logic [PULSE_W-1:0] pulses);
        t_res             r;
        int               rel;
        int               idx;
        bit               is_cnt;
        bit               wr;
        logic [CODE_W-1:0] code;
        r      = '0;
        rel    = int'(off) - int'(OFF_CNT0);
        idx    = rel / 4;
        is_cnt = (rel >= 0) && (rel % 4 == 0) && (idx < NUM_CNT);
        wr     = (mode == MODE_WR);
        if (mode == MODE_RD || mode == MODE_WR) begin
            if (is_cnt) begin
                if (wr) cnt_q[idx] = data;
                else    r.read_data = cnt_q[idx];
            end else if (off == OFF_CTRL) begin
                if (wr) en_q = data[CTRL_EN];
                else    r.read_data = DATA_W'(en_q);
            end else if (off == OFF_EVTYPE) begin
                if (wr) evsel_q = data;
                else    r.read_data = evsel_q;
            end else if (off == OFF_INTM) begin
                if (wr) mask_q = data[MASK_W-1:0];
                else    r.read_data = DATA_W'(mask_q);
            end else if (off == OFF_INTS) begin
                if (!wr) r.read_data = DATA_W'(status_q);
            end else if (off == OFF_INTC) begin
                if (wr) status_q = status_q & ~data[MASK_W-1:0];
            end else begin
                r.access_error = 1'b1;
            end
        end else if (mode == MODE_EVENT && en_q) begin
            for (int i = 0; i < NUM_CNT; i++) begin
                code = evsel_q[8*i +: 8];
                if (code != EVT_NONE && code < NUM_CODES && pulses[code]) begin
                    cnt_q[i] = cnt_q[i] + 1;
                    // wrap past all ones flags overflow
                    if (cnt_q[i] == '0) status_q[i] = 1'b1;
                end
            end
        end
        r.irq = |(status_q & ~mask_q);
        return r;
    endfunction

    task automatic send_item(input logic [1:0]         mode,
                             input logic [OFF_W-1:0]   off,
                             input logic [DATA_W-1:0]  data,
                             input logic [PULSE_W-1:0] pulses);
        if (push_idle_en && $urandom_range(0, 4) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_push         <= 1'b1;
        i_mode         <= mode;
        i_reg_offset   <= off;
        i_write_data   <= data;
        i_event_pulses <= pulses;
        // hold until the transfer happens
        do @(posedge i_clk); while (o_full);
        pending_results.push_back(apply_bus_item(mode, off, data, pulses));
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_read_data, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", o_read_data, want.read_data);
                if (o_access_error !== want.access_error)
                    report_mismatch("access_error", DATA_W'(o_access_error),
                                    DATA_W'(want.access_error));
                if (o_irq !== want.irq)
                    report_mismatch("irq", DATA_W'(o_irq), DATA_W'(want.irq));
            end
        end
    end

    // Result side: random stall bursts plus one long hold for the backpressure test.
    initial begin
        int burst;
        burst = 0;
        i_pop = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_cycles > 0) begin
                i_pop <= 1'b0;
                long_hold_cycles--;
            end else if (burst > 0) begin
                i_pop <= 1'b0;
                burst--;
            end else if (pop_idle_en && $urandom_range(0, 4) == 0) begin
                i_pop <= 1'b0;
                burst = $urandom_range(0, 6);
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    function automatic logic [OFF_W-1:0] pick_offset();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom);
            1, 2:    return OFF_CNT0 + 8'(4 * $urandom_range(0, NUM_CNT - 1));
            3:       return OFF_CNT0 + 8'(4 * $urandom_range(0, NUM_CNT - 1));
            4:       return OFF_CTRL;
            5:       return OFF_EVTYPE;
            6:       return OFF_INTM;
            7:       return OFF_INTS;
            8:       return OFF_INTC;
            default: return OFF_BAD_ALIGN + 8'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_write_data(input logic [OFF_W-1:0] off);
        logic [DATA_W-1:0] d;
        d = $urandom;
        if (off == OFF_CTRL) begin
            if ($urandom_range(0, 4) != 0) d[CTRL_EN] = 1'b1;
        end else if (off == OFF_EVTYPE) begin
            // mostly valid codes so counters actually run
            for (int i = 0; i < NUM_CNT; i++)
                if ($urandom_range(0, 6) != 0)
                    d[8*i +: 8] = 8'($urandom_range(0, NUM_CODES - 1));
        end else if (off >= OFF_CNT0 && off < OFF_CTRL) begin
            // park counters near the wrap point half the time
            if ($urandom_range(0, 1) == 0) d = ALL_ONES - DATA_W'($urandom_range(0, 15));
        end
        return d;
    endfunction

    task automatic send_random_item();
        logic [1:0]       mode;
        logic [OFF_W-1:0] off;
        int               pick;
        pick = $urandom_range(0, 99);
        if      (pick < 25) mode = MODE_RD;
        else if (pick < 55) mode = MODE_WR;
        else if (pick < 95) mode = MODE_EVENT;
        else                mode = MODE_IDLE;
        off = pick_offset();
        send_item(mode, off, pick_write_data(off), 8'($urandom));
    endtask

    task automatic test_reset_values();
        send_item(MODE_RD, OFF_CNT0,   '0, '0);
        send_item(MODE_RD, OFF_CNT3,   '0, '0);
        send_item(MODE_RD, OFF_CTRL,   '0, '0);
        send_item(MODE_RD, OFF_EVTYPE, '0, '0);
        send_item(MODE_RD, OFF_INTM,   '0, '0);
        send_item(MODE_RD, OFF_INTS,   '0, '0);
        send_item(MODE_RD, OFF_INTC,   '0, '0);
    endtask

    task automatic test_register_access();
        send_item(MODE_WR, OFF_CTRL,   ALL_ONES,    '0);
        send_item(MODE_RD, OFF_CTRL,   '0,          '0);
        send_item(MODE_WR, OFF_EVTYPE, EVSEL_MIXED, '0);
        send_item(MODE_RD, OFF_EVTYPE, '0,          '0);
        send_item(MODE_WR, OFF_CNT0,   ALL_ONES,    '0);
        send_item(MODE_WR, OFF_CNT1,   ALL_ONES,    '0);
        send_item(MODE_WR, OFF_CNT3,   ALL_ONES,    '0);
        // status is read only
        send_item(MODE_WR, OFF_INTS,   ALL_ONES,    '0);
        send_item(MODE_RD, OFF_BAD_ALIGN, '0,       '0);
        send_item(MODE_WR, OFF_BAD_TOP,   ALL_ONES, '0);
        send_item(MODE_RD, OFF_BAD_ZERO,  '0,       '0);
        send_item(MODE_IDLE, OFF_BAD_TOP, ALL_ONES, ALL_PULSES);
    endtask

    task automatic test_overflow_and_clear();
        send_item(MODE_EVENT, OFF_CNT0, '0,       ALL_PULSES);
        send_item(MODE_RD,    OFF_CNT1, '0,       '0);
        send_item(MODE_RD,    OFF_INTS, '0,       '0);
        send_item(MODE_WR,    OFF_INTM, '0,       '0);
        send_item(MODE_RD,    OFF_INTC, '0,       '0);
        send_item(MODE_WR,    OFF_INTC, 32'h1,    '0);
        send_item(MODE_WR,    OFF_INTC, ALL_ONES, '0);
    endtask

    task automatic test_random_traffic(input int n);
        repeat (n) send_random_item();
    endtask

    task automatic test_backpressure(input int n);
        long_hold_cycles = LONG_HOLD;
        repeat (n) send_random_item();
    endtask

    initial begin
        for (int i = 0; i < NUM_CNT; i++) cnt_q[i] = '0;
        evsel_q        = ALL_ONES;
        en_q           = 1'b0;
        mask_q         = '1;
        status_q       = '0;
        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_mode         = MODE_RD;
        i_reg_offset   = '0;
        i_write_data   = '0;
        i_event_pulses = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_register_access();
        test_overflow_and_clear();

        push_idle_en = 1'b1;
        pop_idle_en  = 1'b1;
        test_random_traffic(500);
        push_idle_en = 1'b0;
        test_backpressure(60);
        push_idle_en = 1'b1;
        test_random_traffic(400);

        // no idling on either side for the last stretch
        push_idle_en = 1'b0;
        pop_idle_en  = 1'b0;
        test_random_traffic(200);
        i_push <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
